[design/ffse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffse_pkg
// Shared types, codes and helpers for the FIRST/FOLLOW set engine.
// ----------------------------------------------------------------------------
package ffse_pkg;

   localparam int MAX_SYMBOLS_DEF  = 256;
   localparam int NONTERMINALS_DEF = 26;
   localparam int TERMINALS        = 32;

   localparam logic [4:0] START_RESET = 5'd18;
   localparam logic [4:0] END_RESET   = 5'd31;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [1:0] KIND_TERM    = 2'd0;
   localparam logic [1:0] KIND_NONTERM = 2'd1;

   localparam logic [1:0] REG_START_SYMBOL = 2'd0;
   localparam logic [1:0] REG_END_MARKER   = 2'd1;

   typedef struct packed {
      logic       rule_end;
      logic [4:0] index;
      logic [1:0] kind;
      logic [4:0] lhs;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F_INIT,
      ST_F_CHECK,
      ST_F_READ,
      ST_F_SYM,
      ST_F_COMMIT,
      ST_MARK,
      ST_W_CHECK,
      ST_W_FREAD,
      ST_W_FSYM,
      ST_W_TRAIL,
      ST_W_BREAD,
      ST_W_BSYM,
      ST_W_NEXT,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_INIT,
      DP_PASS,
      DP_READ,
      DP_F_SYM,
      DP_F_COMMIT,
      DP_MARK,
      DP_W_FSYM,
      DP_W_TRAIL,
      DP_W_BSYM,
      DP_W_NEXT,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic pos_at_count;
      logic count_zero;
      logic changed;
      logic sym_end;
      logic pos_at_start;
      logic lhs_ok;
      logic emit_last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] term_bit(input logic [4:0] t);
      logic [31:0] r;
      r = '0;
      if (32'(t) < TERMINALS) begin
         r[t] = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/ffse_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffse channel interfaces
// Symbol/command input, set result output and register write channels.
// ----------------------------------------------------------------------------
interface ffse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [4:0] lhs;
   logic [1:0] symbol_kind;
   logic [4:0] symbol_index;
   logic       rule_end;
   modport source (output valid, operation, lhs, symbol_kind, symbol_index, rule_end,
                   input ready);
   modport sink   (input valid, operation, lhs, symbol_kind, symbol_index, rule_end,
                   output ready);
endinterface

interface ffse_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  nonterminal;
   logic        defined;
   logic [31:0] first_terminals;
   logic        first_has_empty;
   logic [31:0] follow_terminals;
   logic        grammar_overflow;
   logic        last;
   modport source (output valid, nonterminal, defined, first_terminals, first_has_empty,
                   follow_terminals, grammar_overflow, last, input ready);
   modport sink   (input valid, nonterminal, defined, first_terminals, first_has_empty,
                   follow_terminals, grammar_overflow, last, output ready);
endinterface

interface ffse_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [4:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/first_follow_set_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_follow_set_engine_unit
// LL(1) FIRST and FOLLOW set engine over a loaded rule store.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per command. A load beat writes one symbol into
//   the rule store, or flags overflow when the store is full, so loads stream
//   back to back. A clear beat empties the grammar.
//   A compute beat clears the sets, runs FIRST passes until no set changes,
//   places the end marker, runs FOLLOW passes until no set changes, then
//   sends one rsp_bus beat per nonterminal, last flagged.
//   A FIRST pass checks for change, reads each symbol and commits each rule. A
//   FOLLOW pass checks for change, reads each symbol of a rule forward, then
//   reads it backward if its left side is a valid nonterminal; all of
//   it is bound by the single-port rule store read. Each phase adds one pass
//   to see no change, and emission sends one nonterminal per cycle when
//   rsp_bus is not stalled.
//   req_bus is not ready during a compute; a stalled rsp_bus holds its beat
//   and pauses emission. A new command is taken while the final result waits.
//   csr_bus writes are always ready and are meant only while idle.
//   Reset empties the grammar and restores start symbol 18 and end marker 31;
//   no clearing sweep is needed.
// ----------------------------------------------------------------------------
module first_follow_set_engine_unit #(
   parameter int MAX_SYMBOLS  = ffse_pkg::MAX_SYMBOLS_DEF,
   parameter int NONTERMINALS = ffse_pkg::NONTERMINALS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ffse_req_if.sink   req_bus,
   ffse_rsp_if.source rsp_bus,
   ffse_csr_if.sink   csr_bus
);

   ffse_pkg::cmd_type    cmd;
   ffse_pkg::status_type status;
   ffse_pkg::entry_type  req_entry;
   logic                 ctrl_ready;

   assign req_bus.ready      = ctrl_ready;
   assign req_entry.rule_end = req_bus.rule_end;
   assign req_entry.index    = req_bus.symbol_index;
   assign req_entry.kind     = req_bus.symbol_kind;
   assign req_entry.lhs      = req_bus.lhs;

   ffse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (ctrl_ready),
      .status        (status),
      .cmd           (cmd)
   );

   ffse_datapath #(
      .MAX_SYMBOLS  (MAX_SYMBOLS),
      .NONTERMINALS (NONTERMINALS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_bus.operation),
      .req_entry     (req_entry),
      .csr_bus       (csr_bus),
      .rsp_bus       (rsp_bus)
   );

endmodule
`default_nettype wire

[design/ffse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffse_ctrl
// Sequencer: walks FIRST passes, FOLLOW passes and result emission.
// ----------------------------------------------------------------------------
module ffse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_operation,
   output      logic                req_ready,
   input  wire ffse_pkg::status_type status,
   output      ffse_pkg::cmd_type    cmd
);

   ffse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffse_pkg::ST_IDLE: begin
            if (req_valid && req_operation == ffse_pkg::OP_COMPUTE) begin
               state_in = ffse_pkg::ST_F_INIT;
            end
         end
         ffse_pkg::ST_F_INIT:  state_in = ffse_pkg::ST_F_CHECK;
         ffse_pkg::ST_F_CHECK: begin
            state_in = (status.changed && !status.count_zero) ?
                       ffse_pkg::ST_F_READ : ffse_pkg::ST_MARK;
         end
         ffse_pkg::ST_F_READ: state_in = ffse_pkg::ST_F_SYM;
         ffse_pkg::ST_F_SYM: begin
            state_in = status.sym_end ? ffse_pkg::ST_F_COMMIT : ffse_pkg::ST_F_READ;
         end
         ffse_pkg::ST_F_COMMIT: begin
            state_in = status.pos_at_count ? ffse_pkg::ST_F_CHECK : ffse_pkg::ST_F_READ;
         end
         ffse_pkg::ST_MARK:    state_in = ffse_pkg::ST_W_CHECK;
         ffse_pkg::ST_W_CHECK: begin
            state_in = (status.changed && !status.count_zero) ?
                       ffse_pkg::ST_W_FREAD : ffse_pkg::ST_EMIT;
         end
         ffse_pkg::ST_W_FREAD: state_in = ffse_pkg::ST_W_FSYM;
         ffse_pkg::ST_W_FSYM: begin
            state_in = status.sym_end ? ffse_pkg::ST_W_TRAIL : ffse_pkg::ST_W_FREAD;
         end
         ffse_pkg::ST_W_TRAIL: begin
            state_in = status.lhs_ok ? ffse_pkg::ST_W_BREAD : ffse_pkg::ST_W_NEXT;
         end
         ffse_pkg::ST_W_BREAD: state_in = ffse_pkg::ST_W_BSYM;
         ffse_pkg::ST_W_BSYM: begin
            state_in = status.pos_at_start ? ffse_pkg::ST_W_NEXT : ffse_pkg::ST_W_BREAD;
         end
         ffse_pkg::ST_W_NEXT: begin
            state_in = status.pos_at_count ? ffse_pkg::ST_W_CHECK : ffse_pkg::ST_W_FREAD;
         end
         ffse_pkg::ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ffse_pkg::ST_IDLE;
            end
         end
         default: state_in = ffse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = ffse_pkg::DP_NOP;
      case (state_ff)
         ffse_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = ffse_pkg::DP_ACCEPT;
            end
         end
         ffse_pkg::ST_F_INIT:   cmd.op = ffse_pkg::DP_INIT;
         ffse_pkg::ST_F_CHECK:  cmd.op = ffse_pkg::DP_PASS;
         ffse_pkg::ST_F_READ:   cmd.op = ffse_pkg::DP_READ;
         ffse_pkg::ST_F_SYM:    cmd.op = ffse_pkg::DP_F_SYM;
         ffse_pkg::ST_F_COMMIT: cmd.op = ffse_pkg::DP_F_COMMIT;
         ffse_pkg::ST_MARK:     cmd.op = ffse_pkg::DP_MARK;
         ffse_pkg::ST_W_CHECK:  cmd.op = ffse_pkg::DP_PASS;
         ffse_pkg::ST_W_FREAD:  cmd.op = ffse_pkg::DP_READ;
         ffse_pkg::ST_W_FSYM:   cmd.op = ffse_pkg::DP_W_FSYM;
         ffse_pkg::ST_W_TRAIL:  cmd.op = ffse_pkg::DP_W_TRAIL;
         ffse_pkg::ST_W_BREAD:  cmd.op = ffse_pkg::DP_READ;
         ffse_pkg::ST_W_BSYM:   cmd.op = ffse_pkg::DP_W_BSYM;
         ffse_pkg::ST_W_NEXT:   cmd.op = ffse_pkg::DP_W_NEXT;
         ffse_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = ffse_pkg::DP_EMIT;
            end
         end
         default: cmd.op = ffse_pkg::DP_NOP;
      endcase
   end

endmodule
`default_nettype wire

[design/ffse_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffse_datapath
// Rule store, set registers, pass scratch registers and result register.
// ----------------------------------------------------------------------------
module ffse_datapath #(
   parameter int MAX_SYMBOLS  = ffse_pkg::MAX_SYMBOLS_DEF,
   parameter int NONTERMINALS = ffse_pkg::NONTERMINALS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffse_pkg::cmd_type     cmd,
   output      ffse_pkg::status_type  status,
   input  wire logic [1:0]           req_operation,
   input  wire ffse_pkg::entry_type   req_entry,
   ffse_csr_if.sink                  csr_bus,
   ffse_rsp_if.source                rsp_bus
);

   localparam int AW = $clog2(MAX_SYMBOLS);
   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int NW = $clog2(NONTERMINALS);
   localparam logic [4:0]    NT5     = 5'(NONTERMINALS);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SYMBOLS);
   localparam logic [NW-1:0] NT_LAST = NW'(NONTERMINALS - 1);

   ffse_pkg::entry_type mem [MAX_SYMBOLS];
   ffse_pkg::entry_type rd_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [NONTERMINALS-1:0] defined_ff, defined_in;
   logic ovf_ff, ovf_in;
   logic [4:0] start_ff, start_in, endm_ff, endm_in;

   logic [31:0] first_ff  [NONTERMINALS];
   logic [31:0] first_in  [NONTERMINALS];
   logic [NONTERMINALS-1:0] empty_ff, empty_in;
   logic [31:0] follow_ff [NONTERMINALS];
   logic [31:0] follow_in [NONTERMINALS];

   logic [CW-1:0] pos_ff, pos_in, s_ff, s_in, e_ff, e_in;
   logic [4:0]  lhs_ff, lhs_in;
   logic [31:0] acc_ff, acc_in, trail_ff, trail_in;
   logic        null_ff, null_in, changed_ff, changed_in, rs_ff, rs_in;
   logic [NW-1:0] n_ff, n_in;

   logic        out_valid_ff, out_valid_in;
   logic [4:0]  out_nt_ff;
   logic        out_def_ff, out_empty_ff, out_ovf_ff, out_last_ff;
   logic [31:0] out_first_ff, out_follow_ff;

   logic          mem_we;
   logic          x_ok, lhs_ok, out_free;
   logic [NW-1:0] xi, li, si;
   logic [31:0]   fx, flx, tb;
   logic          ex;
   logic          nul_cur;
   logic [31:0]   acc_base, nf;
   logic          ne;

   assign csr_bus.ready = 1'b1;

   assign x_ok   = rd_ff.index < NT5;
   assign lhs_ok = lhs_ff < NT5;
   assign xi     = rd_ff.index[NW-1:0];
   assign li     = lhs_ff[NW-1:0];
   assign si     = start_ff[NW-1:0];
   assign fx     = x_ok ? first_ff[xi]  : '0;
   assign flx    = x_ok ? follow_ff[xi] : '0;
   assign ex     = x_ok ? empty_ff[xi]  : 1'b0;
   assign tb     = ffse_pkg::term_bit(rd_ff.index);
   assign out_free = !out_valid_ff || rsp_bus.ready;

   assign mem_we = cmd.op == ffse_pkg::DP_ACCEPT && req_operation == ffse_pkg::OP_LOAD &&
                   count_ff < MAX_CNT;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= req_entry;
      end
      if (cmd.op == ffse_pkg::DP_READ) begin
         rd_ff <= mem[pos_ff[AW-1:0]];
      end
   end

   always_comb begin
      status.pos_at_count = pos_ff == count_ff;
      status.count_zero   = count_ff == '0;
      status.changed      = changed_ff;
      status.sym_end      = rd_ff.rule_end || (pos_ff + CW'(1) == count_ff);
      status.pos_at_start = pos_ff == s_ff;
      status.lhs_ok       = lhs_ok;
      status.emit_last    = n_ff == NT_LAST;
      status.out_free     = out_free;
   end

   always_comb begin
      count_in   = count_ff;
      defined_in = defined_ff;
      ovf_in     = ovf_ff;
      start_in   = start_ff;
      endm_in    = endm_ff;
      first_in   = first_ff;
      empty_in   = empty_ff;
      follow_in  = follow_ff;
      pos_in     = pos_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      lhs_in     = lhs_ff;
      acc_in     = acc_ff;
      trail_in   = trail_ff;
      null_in    = null_ff;
      changed_in = changed_ff;
      rs_in      = rs_ff;
      n_in       = n_ff;
      nul_cur    = rs_ff || null_ff;
      acc_base   = rs_ff ? '0 : acc_ff;
      nf         = '0;
      ne         = 1'b0;

      if (csr_bus.valid) begin
         if (csr_bus.index == ffse_pkg::REG_START_SYMBOL) begin
            start_in = csr_bus.data;
         end else if (csr_bus.index == ffse_pkg::REG_END_MARKER) begin
            endm_in = csr_bus.data;
         end
      end

      case (cmd.op)
         ffse_pkg::DP_ACCEPT: begin
            if (req_operation == ffse_pkg::OP_LOAD) begin
               if (count_ff < MAX_CNT) begin
                  count_in = count_ff + CW'(1);
                  if (req_entry.lhs < NT5) begin
                     defined_in[req_entry.lhs[NW-1:0]] = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (req_operation == ffse_pkg::OP_CLEAR) begin
               count_in   = '0;
               defined_in = '0;
               ovf_in     = 1'b0;
            end
         end
         ffse_pkg::DP_INIT: begin
            for (int i = 0; i < NONTERMINALS; i++) begin
               first_in[i]  = '0;
               follow_in[i] = '0;
            end
            empty_in   = '0;
            changed_in = 1'b1;
         end
         ffse_pkg::DP_PASS: begin
            changed_in = 1'b0;
            pos_in     = '0;
            rs_in      = 1'b1;
            n_in       = '0;
         end
         ffse_pkg::DP_F_SYM: begin
            // a fresh rule starts nullable with an empty accumulator
            acc_in  = acc_base;
            null_in = nul_cur;
            if (nul_cur) begin
               if (rd_ff.kind == ffse_pkg::KIND_TERM) begin
                  acc_in  = acc_base | tb;
                  null_in = 1'b0;
               end else if (rd_ff.kind == ffse_pkg::KIND_NONTERM) begin
                  acc_in  = acc_base | fx;
                  null_in = ex;
               end
            end
            if (rs_ff) begin
               lhs_in = rd_ff.lhs;
            end
            rs_in  = 1'b0;
            pos_in = pos_ff + CW'(1);
         end
         ffse_pkg::DP_F_COMMIT: begin
            if (lhs_ok) begin
               nf = first_ff[li] | acc_ff;
               ne = empty_ff[li] | null_ff;
               if (nf != first_ff[li] || ne != empty_ff[li]) begin
                  changed_in = 1'b1;
               end
               first_in[li] = nf;
               empty_in[li] = ne;
            end
            rs_in = 1'b1;
         end
         ffse_pkg::DP_MARK: begin
            if (start_ff < NT5) begin
               follow_in[si] = follow_ff[si] | ffse_pkg::term_bit(endm_ff);
            end
            changed_in = 1'b1;
         end
         ffse_pkg::DP_W_FSYM: begin
            if (rs_ff) begin
               lhs_in = rd_ff.lhs;
               s_in   = pos_ff;
            end
            rs_in = 1'b0;
            if (rd_ff.rule_end || (pos_ff + CW'(1) == count_ff)) begin
               e_in = pos_ff;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         ffse_pkg::DP_W_TRAIL: begin
            if (lhs_ok) begin
               trail_in = follow_ff[li];
            end else begin
               pos_in = e_ff + CW'(1);
            end
         end
         ffse_pkg::DP_W_BSYM: begin
            if (rd_ff.kind == ffse_pkg::KIND_TERM) begin
               trail_in = tb;
            end else if (rd_ff.kind == ffse_pkg::KIND_NONTERM) begin
               if (x_ok) begin
                  nf = flx | trail_ff;
                  if (nf != flx) begin
                     changed_in = 1'b1;
                  end
                  follow_in[xi] = nf;
                  trail_in = ex ? (trail_ff | fx) : fx;
               end else begin
                  trail_in = '0;
               end
            end
            pos_in = (pos_ff == s_ff) ? e_ff + CW'(1) : pos_ff - CW'(1);
         end
         ffse_pkg::DP_W_NEXT: begin
            rs_in = 1'b1;
         end
         ffse_pkg::DP_EMIT: begin
            n_in = n_ff + NW'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (cmd.op == ffse_pkg::DP_EMIT) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         defined_ff   <= '0;
         ovf_ff       <= 1'b0;
         start_ff     <= ffse_pkg::START_RESET;
         endm_ff      <= ffse_pkg::END_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         defined_ff   <= defined_in;
         ovf_ff       <= ovf_in;
         start_ff     <= start_in;
         endm_ff      <= endm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff   <= first_in;
      empty_ff   <= empty_in;
      follow_ff  <= follow_in;
      pos_ff     <= pos_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      lhs_ff     <= lhs_in;
      acc_ff     <= acc_in;
      trail_ff   <= trail_in;
      null_ff    <= null_in;
      changed_ff <= changed_in;
      rs_ff      <= rs_in;
      n_ff       <= n_in;
      if (cmd.op == ffse_pkg::DP_EMIT) begin
         out_nt_ff     <= 5'(n_ff);
         out_def_ff    <= defined_ff[n_ff];
         out_first_ff  <= first_ff[n_ff];
         out_empty_ff  <= empty_ff[n_ff];
         out_follow_ff <= follow_ff[n_ff];
         out_ovf_ff    <= ovf_ff;
         out_last_ff   <= n_ff == NT_LAST;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.nonterminal      = out_nt_ff;
   assign rsp_bus.defined          = out_def_ff;
   assign rsp_bus.first_terminals  = out_first_ff;
   assign rsp_bus.first_has_empty  = out_empty_ff;
   assign rsp_bus.follow_terminals = out_follow_ff;
   assign rsp_bus.grammar_overflow = out_ovf_ff;
   assign rsp_bus.last             = out_last_ff;

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives grammar loads, clears and compute commands into the set engine and
// checks every emitted FIRST/FOLLOW beat against a local behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NT = ffse_pkg::NONTERMINALS_DEF;
   localparam int MAXS = ffse_pkg::MAX_SYMBOLS_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   // codes the block accepts but treats as no-ops or empty symbols
   localparam logic [1:0] OP_SPARE   = 2'd3;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] lhs;
      logic [1:0] symbol_kind;
      logic [4:0] symbol_index;
      logic       rule_end;
   } cmd_beat_type;

   typedef struct packed {
      logic [4:0]  nonterminal;
      logic        defined;
      logic [31:0] first_terminals;
      logic        first_has_empty;
      logic [31:0] follow_terminals;
      logic        grammar_overflow;
      logic        last;
   } set_beat_type;

   logic clock;
   logic reset;

   ffse_req_if req_bus();
   ffse_rsp_if rsp_bus();
   ffse_csr_if csr_bus();

   first_follow_set_engine_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   // predictor state
   ffse_pkg::entry_type grammar_mem[MAXS];
   int          sym_count;
   logic [31:0] first_bits[NT];
   logic        first_eps[NT];
   logic [31:0] follow_bits[NT];
   logic [25:0] defined_bits;
   logic        store_overflow;
   logic [4:0]  start_nt;
   logic [4:0]  end_term;

   cmd_beat_type cmd_queue[$];
   set_beat_type sets_expected[$];
   int  errors;
   int  cycles;
   bit  tx_quiet;        // no sender idling
   bit  rx_quiet;
   int  rx_hold;         // long receiver stall, counted below
   bit  hold_arm;
   bit  hold_done;
   int  tx_gap;
   int  rx_gap;

   function automatic logic [31:0] tbit(input logic [4:0] t);
      return 32'd1 << t;
   endfunction

   function automatic int rule_tail(input int s);
      int e;
      e = s;
      while (e + 1 < sym_count && !grammar_mem[e].rule_end) e++;
      return e;
   endfunction

   function automatic bit first_sweep();
      bit chg;
      int s, e, p;
      logic [31:0] acc;
      bit nul;
      ffse_pkg::entry_type en;
      chg = 0;
      s = 0;
      while (s < sym_count) begin
         e = rule_tail(s);
         if (grammar_mem[s].lhs < NT) begin
            acc = first_bits[grammar_mem[s].lhs];
            nul = 1;
            for (p = s; p <= e && nul; p++) begin
               en = grammar_mem[p];
               if (en.kind == ffse_pkg::KIND_TERM) begin
                  acc |= tbit(en.index);
                  nul = 0;
               end else if (en.kind == ffse_pkg::KIND_NONTERM) begin
                  if (en.index < NT) begin
                     acc |= first_bits[en.index];
                     nul = first_eps[en.index];
                  end else nul = 0;
               end
            end
            if (acc != first_bits[grammar_mem[s].lhs]) begin
               first_bits[grammar_mem[s].lhs] = acc;
               chg = 1;
            end
            if (nul && !first_eps[grammar_mem[s].lhs]) begin
               first_eps[grammar_mem[s].lhs] = 1;
               chg = 1;
            end
         end
         s = e + 1;
      end
      return chg;
   endfunction

   function automatic bit follow_sweep();
      bit chg;
      int s, e, p;
      logic [31:0] trail, nf;
      ffse_pkg::entry_type en;
      chg = 0;
      s = 0;
      while (s < sym_count) begin
         e = rule_tail(s);
         if (grammar_mem[s].lhs < NT) begin
            trail = follow_bits[grammar_mem[s].lhs];
            for (p = e; p >= s; p--) begin
               en = grammar_mem[p];
               if (en.kind == ffse_pkg::KIND_TERM) trail = tbit(en.index);
               else if (en.kind == ffse_pkg::KIND_NONTERM) begin
                  if (en.index < NT) begin
                     nf = follow_bits[en.index] | trail;
                     if (nf != follow_bits[en.index]) begin
                        follow_bits[en.index] = nf;
                        chg = 1;
                     end
                     if (first_eps[en.index]) trail |= first_bits[en.index];
                     else trail = first_bits[en.index];
                  end else trail = '0;
               end
            end
         end
         s = e + 1;
      end
      return chg;
   endfunction

   task automatic predict_sets(input cmd_beat_type c);
      set_beat_type r;
      if (c.operation == ffse_pkg::OP_LOAD) begin
         if (sym_count < MAXS) begin
            grammar_mem[sym_count] = {c.rule_end, c.symbol_index, c.symbol_kind, c.lhs};
            sym_count++;
            if (c.lhs < NT) defined_bits[c.lhs] = 1'b1;
         end else store_overflow = 1;
      end else if (c.operation == ffse_pkg::OP_CLEAR) begin
         sym_count = 0;
         defined_bits = '0;
         store_overflow = 0;
      end else if (c.operation == ffse_pkg::OP_COMPUTE) begin
         for (int n = 0; n < NT; n++) begin
            first_bits[n] = '0;
            first_eps[n] = 0;
            follow_bits[n] = '0;
         end
         while (first_sweep()) ;
         if (start_nt < NT) follow_bits[start_nt] |= tbit(end_term);
         while (follow_sweep()) ;
         for (int n = 0; n < NT; n++) begin
            r.nonterminal = 5'(n);
            r.defined = defined_bits[n];
            r.first_terminals = first_bits[n];
            r.first_has_empty = first_eps[n];
            r.follow_terminals = follow_bits[n];
            r.grammar_overflow = store_overflow;
            r.last = (n == NT - 1);
            sets_expected.insert(sets_expected.size(), r);
         end
      end
   endtask

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap <= 0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // hold beat
      end else if (tx_gap > 0) begin
         req_bus.valid <= 1'b0;
         tx_gap <= tx_gap - 1;
      end else if (cmd_queue.size() > 0 && !(req_bus.valid && cmd_queue.size() == 0)) begin
         if (!tx_quiet && $urandom_range(0, 7) == 0) begin
            req_bus.valid <= 1'b0;
            tx_gap <= $urandom_range(1, 19) - 1;
         end else begin
            req_bus.valid <= 1'b1;
            {req_bus.operation, req_bus.lhs, req_bus.symbol_kind, req_bus.symbol_index,
             req_bus.rule_end} <= cmd_queue[0];
            predict_sets(cmd_queue.pop_front());
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // long receiver stall, started at the first result once armed
   always @(posedge clock) begin
      if (reset) begin
         rx_hold <= 0;
         hold_done <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
      end else if (hold_arm && !hold_done && rsp_bus.valid) begin
         rx_hold <= 400;
         hold_done <= 1'b1;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      set_beat_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_gap <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.nonterminal, rsp_bus.defined, rsp_bus.first_terminals,
                   rsp_bus.first_has_empty, rsp_bus.follow_terminals,
                   rsp_bus.grammar_overflow, rsp_bus.last};
            if (sets_expected.size() == 0) begin
               $error("unexpected result beat nonterminal=%0d", got.nonterminal);
               errors++;
            end else begin
               want = sets_expected.pop_front();
               if (got.nonterminal != want.nonterminal) begin
                  $error("nonterminal exp %0d got %0d", want.nonterminal, got.nonterminal);
                  errors++;
               end
               if (got.defined != want.defined) begin
                  $error("defined exp %0d got %0d", want.defined, got.defined);
                  errors++;
               end
               if (got.first_terminals != want.first_terminals) begin
                  $error("first_terminals exp %h got %h", want.first_terminals,
                         got.first_terminals);
                  errors++;
               end
               if (got.first_has_empty != want.first_has_empty) begin
                  $error("first_has_empty exp %0d got %0d", want.first_has_empty,
                         got.first_has_empty);
                  errors++;
               end
               if (got.follow_terminals != want.follow_terminals) begin
                  $error("follow_terminals exp %h got %h", want.follow_terminals,
                         got.follow_terminals);
                  errors++;
               end
               if (got.grammar_overflow != want.grammar_overflow) begin
                  $error("grammar_overflow exp %0d got %0d", want.grammar_overflow,
                         got.grammar_overflow);
                  errors++;
               end
               if (got.last != want.last) begin
                  $error("last exp %0d got %0d", want.last, got.last);
                  errors++;
               end
            end
         end
         if (rx_hold > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            rx_gap <= rx_gap - 1;
         end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            rx_gap <= $urandom_range(1, 19) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic cmd_beat_type mk(input logic [1:0] op, input logic [4:0] l,
                                       input logic [1:0] k, input logic [4:0] x,
                                       input logic e);
      cmd_beat_type c;
      c = {op, l, k, x, e};
      return c;
   endfunction

   task automatic add_cmd(input cmd_beat_type c);
      cmd_queue.insert(cmd_queue.size(), c);
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() > 0 || req_bus.valid || sets_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [4:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == ffse_pkg::REG_START_SYMBOL) start_nt = val;
      else end_term = val;
   endtask

   // random grammar: mostly well formed rules over a few nonterminals
   task automatic queue_grammar(input int n_syms, input int span);
      logic [4:0] l;
      int len;
      int done;
      done = 0;
      while (done < n_syms) begin
         l = (span < 26 && $urandom_range(0, 19) != 0) ? 5'($urandom_range(0, span - 1))
                                                       : 5'($urandom_range(0, 31));
         len = $urandom_range(1, 4);
         for (int i = 0; i < len && done < n_syms; i++) begin
            logic [1:0] k;
            logic [4:0] x;
            k = 2'($urandom_range(0, 9) < 4 ? ffse_pkg::KIND_TERM :
                   ($urandom_range(0, 9) < 8 ? ffse_pkg::KIND_NONTERM : $urandom_range(2, 3)));
            x = (k == ffse_pkg::KIND_NONTERM && $urandom_range(0, 9) != 0) ?
                5'($urandom_range(0, span - 1)) : 5'($urandom);
            add_cmd(mk(ffse_pkg::OP_LOAD, l, k, x, (i == len - 1) ? 1'b1 : 1'($urandom)));
            done++;
         end
      end
   endtask

   initial begin
      int phase;
      errors = 0;
      cycles = 0;
      tx_quiet = 0;
      rx_quiet = 0;
      hold_arm = 0;
      sym_count = 0;
      defined_bits = '0;
      store_overflow = 0;
      start_nt = ffse_pkg::START_RESET;
      end_term = ffse_pkg::END_RESET;
      reset = 1;
      req_bus.valid = 0;
      req_bus.operation = ffse_pkg::OP_LOAD;
      req_bus.lhs = '0;
      req_bus.symbol_kind = '0;
      req_bus.symbol_index = '0;
      req_bus.rule_end = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.index = ffse_pkg::REG_START_SYMBOL;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: S -> A b Z ; A -> c | empty ; with edge indices
      add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));        // empty grammar
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd18, ffse_pkg::KIND_NONTERM, 5'd0, 1'b0));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd18, ffse_pkg::KIND_TERM, 5'd1, 1'b0));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd18, ffse_pkg::KIND_NONTERM, 5'd25, 1'b1));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd0, ffse_pkg::KIND_TERM, 5'd31, 1'b1));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd0, KIND_EMPTY, 5'd0, 1'b1));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd25, KIND_SPARE, 5'd31, 1'b0));  // empty inside rule
      // nonterminal out of range
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd25, ffse_pkg::KIND_NONTERM, 5'd31, 1'b1));
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd31, ffse_pkg::KIND_TERM, 5'd0, 1'b1)); // ignored lhs
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd1, ffse_pkg::KIND_NONTERM, 5'd0, 1'b0));
      // unterminated tail
      add_cmd(mk(ffse_pkg::OP_LOAD, 5'd1, ffse_pkg::KIND_NONTERM, 5'd18, 1'b0));
      add_cmd(mk(OP_SPARE, 5'h1f, KIND_SPARE, 5'h1f, 1'b1));             // unused op
      add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
      wait_drained();
      csr_write(ffse_pkg::REG_START_SYMBOL, 5'd0);
      csr_write(ffse_pkg::REG_END_MARKER, 5'd0);
      add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
      wait_drained();
      csr_write(ffse_pkg::REG_START_SYMBOL, 5'd31);                      // out of range
      add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
      add_cmd(mk(ffse_pkg::OP_CLEAR, 5'd0, 2'd0, 5'd0, 1'b0));
      add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
      wait_drained();

      // random phases
      for (phase = 0; phase < 8; phase++) begin
         csr_write(ffse_pkg::REG_START_SYMBOL, 5'($urandom_range(0, 27)));
         csr_write(ffse_pkg::REG_END_MARKER, 5'($urandom));
         if (phase >= 6) begin
            tx_quiet = 1;
            rx_quiet = 1;
         end
         add_cmd(mk(ffse_pkg::OP_CLEAR, 5'd0, 2'd0, 5'd0, 1'b0));
         queue_grammar($urandom_range(10, 24), $urandom_range(2, 8));
         add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
         if (phase == 2) begin
            hold_arm = 1;                  // long receiver stall while loads queue behind
            queue_grammar(6, 4);
            add_cmd(mk(ffse_pkg::OP_COMPUTE, 5'd0, 2'd0, 5'd0, 1'b0));
         end
         if ($urandom_range(0, 3) == 0) add_cmd(mk(OP_SPARE, 5'($urandom), 2'($urandom),
                                                   5'($urandom), 1'($urandom)));
         wait_drained();                   // sender pauses for every result
      end

      wait_drained();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
